>>> src/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// shared types, constants and tables of the planar frame transform unit
// ----------------------------------------------------------------------------
package pft_pkg;

  // default binary angle width, 2^ANGLE_BITS is one full turn
  localparam int ANGLE_BITS_DEF = 16;

  // cordic rotator, q2.30 gain compensated start value
  localparam int CORDIC_STAGES = 30;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [29:0] ATAN_LUT [CORDIC_STAGES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  // configuration register map, word index
  typedef enum logic [1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_FRAME_ANGLE = 2'd2
  } pft_reg_t;

  // direction selector of an input word
  localparam logic CMD_LOCAL_TO_WORLD = 1'b0;
  localparam logic CMD_WORLD_TO_LOCAL = 1'b1;

  // sine/cosine sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROT,
    ST_MAP
  } pft_sc_state_t;

  // sine/cosine of the frame angle and busy status
  typedef struct packed {
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
    logic               busy;
  } pft_trig_t;

endpackage

>>> src/pft_sincos.sv
// ----------------------------------------------------------------------------
// pft_sincos
// iterative cordic, one micro-rotation per cycle, gives cos and sin in q2.30
// ----------------------------------------------------------------------------
module pft_sincos
  import pft_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output pft_trig_t             trig
);

  localparam logic [4:0] LAST_IDX = 5'(CORDIC_STAGES - 1);

  pft_sc_state_t      state_r, state_nxt;
  logic [4:0]         idx_r;
  logic [1:0]         quad_r;
  logic signed [32:0] x_r, y_r, z_r;
  logic signed [32:0] xs, ys, atan_s;
  logic signed [31:0] cos_r, sin_r;
  logic [31:0]        ang32;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_LOAD: state_nxt = ST_ROT;
      ST_ROT:  if (idx_r == LAST_IDX) state_nxt = ST_MAP;
      ST_MAP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (start) state_nxt = ST_LOAD;
  end

  // outputs
  always_comb begin
    trig.busy    = (state_r != ST_IDLE);
    trig.cos_q30 = cos_r;
    trig.sin_q30 = sin_r;
  end

  // angle widened to 32 bits per turn, floor shifts of the rotation
  always_comb begin
    ang32  = {angle, {(32 - ANGLE_BITS){1'b0}}};
    xs     = x_r >>> idx_r;
    ys     = y_r >>> idx_r;
    atan_s = $signed({3'b000, ATAN_LUT[idx_r]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: idx_r <= '0;
        ST_ROT:  idx_r <= idx_r + 5'd1;
        default: idx_r <= idx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        quad_r <= ang32[31:30];
        z_r    <= $signed({3'b000, ang32[29:0]});
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
      end
      ST_ROT: begin
        if (!z_r[32]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_s;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_s;
        end
      end
      ST_MAP: begin
        case (quad_r)
          2'd0: begin
            cos_r <= 32'(x_r);
            sin_r <= 32'(y_r);
          end
          2'd1: begin
            cos_r <= 32'(-y_r);
            sin_r <= 32'(x_r);
          end
          2'd2: begin
            cos_r <= 32'(-x_r);
            sin_r <= 32'(-y_r);
          end
          default: begin
            cos_r <= 32'(y_r);
            sin_r <= 32'(-x_r);
          end
        endcase
      end
      default: begin
        cos_r <= cos_r;
      end
    endcase
  end

endmodule

>>> src/planar_frame_transform_unit.sv
// ----------------------------------------------------------------------------
// planar_frame_transform_unit
// converts a pose between world frame and a configurable local frame
// ----------------------------------------------------------------------------
// A word on the input stream carries a point (q15.16 x and y) and a heading
// (binary angle); in_tuser picks local to world (0) or world to local (1).
// Local to world rotates the point by the frame angle and adds the origin;
// world to local subtracts the origin and rotates by minus the frame angle.
// Headings wrap, coordinates saturate and out_tuser flags a clamp. The data
// path is a four stage pipeline (input/subtract, multiply, sum/round,
// origin add/clamp) that takes one word per clock unless back-pressure on
// out_tready or a busy cordic holds it; per-stage handshaking lets the
// pipe keep filling while a result waits on out_tready. Sine and cosine of
// the frame angle come from an iterative cordic that runs one rotation per
// clock: after reset and after every frame_angle write in_tready stays low
// while it recomputes. Write the registers only while no word is in flight.
module planar_frame_transform_unit
  import pft_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int DATA_W    = ((64 + ANGLE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // point_x, point_y, heading, zero pad
  input  logic              in_tuser,   // cmd
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_x, out_y, out_heading, zero pad
  output logic              out_tuser,  // saturated
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;
  localparam logic signed [66:0] RND_HALF = 67'sd536870912;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic signed [31:0]    origin_x_r, origin_y_r;
  logic [ANGLE_BITS-1:0] frame_angle_r;
  logic                  cfg_we;
  pft_reg_t              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = pft_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      frame_angle_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ORIGIN_X:    origin_x_r    <= $signed(cfg_pwdata);
        REG_ORIGIN_Y:    origin_y_r    <= $signed(cfg_pwdata);
        REG_FRAME_ANGLE: frame_angle_r <= cfg_pwdata[ANGLE_BITS-1:0];
        default:         frame_angle_r <= frame_angle_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:    cfg_prdata = origin_x_r;
      REG_ORIGIN_Y:    cfg_prdata = origin_y_r;
      REG_FRAME_ANGLE: cfg_prdata = 32'(frame_angle_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sine/cosine of the frame angle, redone after reset and on every frame angle write
  // ---------------------------------------------------------------------------
  pft_trig_t trig;
  logic      trig_start;

  assign trig_start = cfg_we && (cfg_idx == REG_FRAME_ANGLE);

  pft_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk  (clk),
    .rst_n(rst_n),
    .start(trig_start),
    .angle(frame_angle_r),
    .trig (trig)
  );

  // ---------------------------------------------------------------------------
  // pipeline handshake: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1 && !trig.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid && in_tready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: operand select, origin subtract for world to local, heading
  // ---------------------------------------------------------------------------
  logic signed [31:0]    in_px, in_py;
  logic [ANGLE_BITS-1:0] in_hd;
  logic signed [32:0]    a_nxt, b_nxt;
  logic [ANGLE_BITS-1:0] hd_nxt;
  logic signed [32:0]    a1_r, b1_r;
  logic [ANGLE_BITS-1:0] hd1_r;
  logic                  cmd1_r;

  always_comb begin
    in_px = $signed(in_tdata[31:0]);
    in_py = $signed(in_tdata[63:32]);
    in_hd = in_tdata[64 +: ANGLE_BITS];
    if (in_tuser == CMD_WORLD_TO_LOCAL) begin
      a_nxt  = 33'(in_px) - 33'(origin_x_r);
      b_nxt  = 33'(in_py) - 33'(origin_y_r);
      hd_nxt = in_hd - frame_angle_r;
    end else begin
      a_nxt  = 33'(in_px);
      b_nxt  = 33'(in_py);
      hd_nxt = in_hd + frame_angle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid && in_tready) begin
      a1_r   <= a_nxt;
      b1_r   <= b_nxt;
      hd1_r  <= hd_nxt;
      cmd1_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: four products; the sine changes sign for world to local
  // ---------------------------------------------------------------------------
  logic signed [32:0]    c_op, s_op;
  logic signed [65:0]    p_ac_r, p_bs_r, p_bc_r, p_as_r;
  logic [ANGLE_BITS-1:0] hd2_r;
  logic                  cmd2_r;

  always_comb begin
    c_op = 33'(trig.cos_q30);
    s_op = (cmd1_r == CMD_WORLD_TO_LOCAL) ? -33'(trig.sin_q30) : 33'(trig.sin_q30);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p_ac_r <= 66'(a1_r) * 66'(c_op);
      p_bs_r <= 66'(b1_r) * 66'(s_op);
      p_bc_r <= 66'(b1_r) * 66'(c_op);
      p_as_r <= 66'(a1_r) * 66'(s_op);
      hd2_r  <= hd1_r;
      cmd2_r <= cmd1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: exact sums, rounded once from q30 (half up, floor shift)
  // ---------------------------------------------------------------------------
  logic signed [66:0]    sum_x, sum_y;
  logic signed [36:0]    rx3_r, ry3_r;
  logic [ANGLE_BITS-1:0] hd3_r;
  logic                  cmd3_r;

  always_comb begin
    sum_x = 67'(p_ac_r) - 67'(p_bs_r) + RND_HALF;
    sum_y = 67'(p_bc_r) + 67'(p_as_r) + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      rx3_r  <= $signed(sum_x[66:30]);
      ry3_r  <= $signed(sum_y[66:30]);
      hd3_r  <= hd2_r;
      cmd3_r <= cmd2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: origin add for local to world, clamp to 32 bits, output register
  // ---------------------------------------------------------------------------
  logic signed [37:0]    tx, ty;
  logic signed [31:0]    ox_nxt, oy_nxt;
  logic                  sx, sy;
  logic signed [31:0]    x4_r, y4_r;
  logic [ANGLE_BITS-1:0] hd4_r;
  logic                  sat4_r;

  always_comb begin
    if (cmd3_r == CMD_LOCAL_TO_WORLD) begin
      tx = 38'(rx3_r) + 38'(origin_x_r);
      ty = 38'(ry3_r) + 38'(origin_y_r);
    end else begin
      tx = 38'(rx3_r);
      ty = 38'(ry3_r);
    end
    sx = 1'b1;
    sy = 1'b1;
    if (tx > SAT_MAX)      ox_nxt = 32'sh7fffffff;
    else if (tx < SAT_MIN) ox_nxt = 32'sh80000000;
    else begin
      ox_nxt = 32'(tx);
      sx     = 1'b0;
    end
    if (ty > SAT_MAX)      oy_nxt = 32'sh7fffffff;
    else if (ty < SAT_MIN) oy_nxt = 32'sh80000000;
    else begin
      oy_nxt = 32'(ty);
      sy     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      x4_r   <= ox_nxt;
      y4_r   <= oy_nxt;
      hd4_r  <= hd3_r;
      sat4_r <= sx | sy;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = DATA_W'({hd4_r, y4_r, x4_r});
  assign out_tuser  = sat4_r;

endmodule

>>> src/pft_checker.sv
// ----------------------------------------------------------------------------
// pft_checker
// port level checks of the planar frame transform unit, bound to the top
// ----------------------------------------------------------------------------
module pft_checker
  import pft_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int DATA_W    = ((64 + ANGLE_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tuser,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic              cfg_pready,
  input logic [3:0]        cfg_paddr
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // the clamp flag only comes with a coordinate at a range limit
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0] == 32'h7fffffff || out_tdata[31:0] == 32'h80000000 ||
      out_tdata[63:32] == 32'h7fffffff || out_tdata[63:32] == 32'h80000000)
    else $error("saturated flag without a clamped coordinate");

  // an angle write stops the input while sine and cosine are redone
  a_angle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
    cfg_paddr[3:2] == REG_FRAME_ANGLE |=> !in_tready)
    else $error("input taken right after a frame angle write");

  // out of reset the input waits for the first sine/cosine
  a_reset_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready && !out_tvalid)
    else $error("block ready right after reset");

endmodule

bind planar_frame_transform_unit pft_checker #(
  .ANGLE_BITS(ANGLE_BITS)
) u_pft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_psel   (cfg_psel),
  .cfg_penable(cfg_penable),
  .cfg_pwrite (cfg_pwrite),
  .cfg_pready (cfg_pready),
  .cfg_paddr  (cfg_paddr)
);
